[src/observer_state_feedback_pi_control_core_defines.svh]
// assertion macros for the observer state feedback controller
`ifndef OBSERVER_STATE_FEEDBACK_PI_CONTROL_CORE_DEFINES_SVH
`define OBSERVER_STATE_FEEDBACK_PI_CONTROL_CORE_DEFINES_SVH

// checked at every clock edge outside reset
`define OSFPI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every clock edge, reset included
`define OSFPI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/osfpi_pkg.sv]
// ----------------------------------------------------------------------------
// osfpi_pkg
// types, constants and the step table of the observer state feedback controller
// ----------------------------------------------------------------------------
`default_nettype none

package osfpi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DUTY_BITS = 12;
  localparam int MV_W      = 12;
  localparam int VOLT_W    = 20;
  localparam int ERR_W     = 21;
  localparam int GAIN_W    = 32;
  localparam int OPA_W     = 33;
  localparam int ACC_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam longint Q_ONE = longint'(1) << FRAC_BITS;
  localparam logic [VOLT_W-1:0] VOLT_MAX = VOLT_W'(12 * Q_ONE);
  localparam longint BIG_LIMIT = longint'(1) << 61;
  localparam logic [63:0] BIG_MAG = 64'(BIG_LIMIT);
  localparam logic [63:0] HI_LIMIT = 64'(longint'(1) << (29 + FRAC_BITS));

  // polynomial and fixed plant coefficients, rounded to nearest
  localparam longint C3_Q  = (longint'(1506) * Q_ONE + 5000) / 10000;
  localparam longint C2_Q  = (longint'(487) * Q_ONE + 500) / 1000;
  localparam longint C1_Q  = (longint'(40233) * Q_ONE + 5000) / 10000;
  localparam longint C0_Q  = (longint'(358) * Q_ONE + 5000) / 10000;
  localparam longint A21_Q = -((longint'(846) * Q_ONE + 500) / 1000);
  localparam longint A22_Q = (longint'(1844) * Q_ONE + 500) / 1000;

  // reciprocal constants for the millivolt scaling
  localparam int     SP_DIV        = 3300;
  localparam int     SP_RECIP_SH   = 43;
  localparam longint SP_RECIP      = (longint'(1) << SP_RECIP_SH) / SP_DIV;
  localparam int     V_DIV         = 1000;
  localparam int     V_RECIP_SH    = 41;
  localparam longint V_RECIP       = (longint'(1) << V_RECIP_SH) / V_DIV;
  localparam int     DIV3_MUL      = 43691;
  localparam int     DIV3_SH       = 17;

  // register reset values
  localparam logic signed [GAIN_W-1:0] K1_RESET = 32'sd3158540;
  localparam logic signed [GAIN_W-1:0] K2_RESET = -32'sd1830204;
  localparam logic signed [GAIN_W-1:0] KI_RESET = -32'sd125239;
  localparam logic signed [GAIN_W-1:0] L1_RESET = 32'sd120848;
  localparam logic signed [GAIN_W-1:0] L2_RESET = 32'sd166743;
  localparam logic signed [GAIN_W-1:0] B1_RESET = 32'sd7445;
  localparam logic signed [GAIN_W-1:0] B2_RESET = 32'sd8756;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K1 = 3'd0,
    CFG_K2 = 3'd1,
    CFG_KI = 3'd2,
    CFG_L1 = 3'd3,
    CFG_L2 = 3'd4,
    CFG_B1 = 3'd5,
    CFG_B2 = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SP_MUL, S_SP_FIX, S_V_MUL, S_V_FIX,
    S_MAC_HI, S_MAC_LO, S_MAC_ACC, S_SAVE, S_COMMIT, S_DONE
  } state_t;

  typedef enum logic [1:0] {MUL_SP, MUL_V, MUL_HI, MUL_LO} mul_sel_t;

  typedef enum logic [3:0] {
    A_C3, A_ACC, A_L1, A_B1, A_A21, A_A22, A_B2, A_L2, A_NKI, A_K1, A_K2
  } a_sel_t;

  typedef enum logic [2:0] {B_V, B_DIFF, B_E1, B_E2, B_U, B_SUM} b_sel_t;

  typedef enum logic [2:0] {
    BASE_ACC, BASE_ZERO, BASE_E2, BASE_NC2, BASE_C1, BASE_NC0
  } base_sel_t;

  typedef enum logic [1:0] {SAVE_NONE, SAVE_FB, SAVE_N1, SAVE_N2} save_sel_t;

  typedef logic [3:0] step_t;
  localparam step_t STEP_FB   = 4'd2;
  localparam step_t STEP_N1   = 4'd4;
  localparam step_t STEP_N2   = 4'd8;
  localparam step_t STEP_LAST = 4'd11;

  typedef struct packed {
    a_sel_t    a_sel;
    b_sel_t    b_sel;
    base_sel_t base_sel;
    logic      neg;
  } mac_cmd_t;

  typedef struct packed {
    logic      capture;
    mul_sel_t  mul_sel;
    logic      sp_fix;
    logic      v_fix;
    logic      hi_load;
    logic      acc_load;
    save_sel_t save;
    logic      commit;
    logic      out_load;
    mac_cmd_t  mac;
  } dp_cmd_t;

  // acc <= sat(base +/- qmul(a, b)) for each step
  function automatic mac_cmd_t mac_cmd(input step_t step);
    mac_cmd_t c;
    c = '{a_sel: A_ACC, b_sel: B_V, base_sel: BASE_ACC, neg: 1'b0};
    case (step)
      4'd0:  c = '{a_sel: A_C3,  b_sel: B_V,    base_sel: BASE_NC2,  neg: 1'b0};
      4'd1:  c = '{a_sel: A_ACC, b_sel: B_V,    base_sel: BASE_C1,   neg: 1'b0};
      4'd2:  c = '{a_sel: A_ACC, b_sel: B_V,    base_sel: BASE_NC0,  neg: 1'b0};
      4'd3:  c = '{a_sel: A_L1,  b_sel: B_DIFF, base_sel: BASE_E2,   neg: 1'b0};
      4'd4:  c = '{a_sel: A_B1,  b_sel: B_U,    base_sel: BASE_ACC,  neg: 1'b0};
      4'd5:  c = '{a_sel: A_A21, b_sel: B_E1,   base_sel: BASE_ZERO, neg: 1'b0};
      4'd6:  c = '{a_sel: A_A22, b_sel: B_E2,   base_sel: BASE_ACC,  neg: 1'b0};
      4'd7:  c = '{a_sel: A_B2,  b_sel: B_U,    base_sel: BASE_ACC,  neg: 1'b0};
      4'd8:  c = '{a_sel: A_L2,  b_sel: B_DIFF, base_sel: BASE_ACC,  neg: 1'b0};
      4'd9:  c = '{a_sel: A_NKI, b_sel: B_SUM,  base_sel: BASE_ZERO, neg: 1'b0};
      4'd10: c = '{a_sel: A_K1,  b_sel: B_E1,   base_sel: BASE_ACC,  neg: 1'b1};
      4'd11: c = '{a_sel: A_K2,  b_sel: B_E2,   base_sel: BASE_ACC,  neg: 1'b1};
      default: c = '{a_sel: A_ACC, b_sel: B_V, base_sel: BASE_ACC, neg: 1'b0};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[src/osfpi_in_if.sv]
// ----------------------------------------------------------------------------
// osfpi_in_if
// input channel: setpoint and feedback readings with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface osfpi_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] setpoint_millivolts;
  logic [11:0] feedback_millivolts;

  modport source (output valid, output setpoint_millivolts, output feedback_millivolts,
                  input ready);
  modport sink (input valid, input setpoint_millivolts, input feedback_millivolts,
                output ready);
endinterface

`default_nettype wire

[src/osfpi_out_if.sv]
// ----------------------------------------------------------------------------
// osfpi_out_if
// result channel: pwm duty, drive and error with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface osfpi_out_if;
  logic               valid;
  logic               ready;
  logic        [11:0] pwm_duty;
  logic        [19:0] drive_volts;
  logic signed [20:0] error_volts;

  modport source (output valid, output pwm_duty, output drive_volts, output error_volts,
                  input ready);
  modport sink (input valid, input pwm_duty, input drive_volts, input error_volts,
                output ready);
endinterface

`default_nettype wire

[src/osfpi_ctrl.sv]
// ----------------------------------------------------------------------------
// osfpi_ctrl
// sequencer: scaling, twelve multiply-accumulate steps, commit and output
// ----------------------------------------------------------------------------
`default_nettype none

module osfpi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output osfpi_pkg::dp_cmd_t     cmd
);
  import osfpi_pkg::*;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    cmd         = '0;
    cmd.mul_sel = MUL_HI;
    cmd.save    = SAVE_NONE;
    cmd.mac     = mac_cmd(step_r);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SP_MUL;
        end
      end
      S_SP_MUL: begin
        cmd.mul_sel = MUL_SP;
        state_nxt   = S_SP_FIX;
      end
      S_SP_FIX: begin
        cmd.sp_fix = 1'b1;
        state_nxt  = S_V_MUL;
      end
      S_V_MUL: begin
        cmd.mul_sel = MUL_V;
        state_nxt   = S_V_FIX;
      end
      S_V_FIX: begin
        cmd.v_fix = 1'b1;
        step_nxt  = '0;
        state_nxt = S_MAC_HI;
      end
      S_MAC_HI: begin
        cmd.mul_sel = MUL_HI;
        state_nxt   = S_MAC_LO;
      end
      S_MAC_LO: begin
        cmd.mul_sel = MUL_LO;
        cmd.hi_load = 1'b1;
        state_nxt   = S_MAC_ACC;
      end
      S_MAC_ACC: begin
        cmd.acc_load = 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = S_COMMIT;
        end else if (step_r == STEP_FB || step_r == STEP_N1 || step_r == STEP_N2) begin
          state_nxt = S_SAVE;
        end else begin
          step_nxt  = step_r + 4'd1;
          state_nxt = S_MAC_HI;
        end
      end
      S_SAVE: begin
        if (step_r == STEP_FB) begin
          cmd.save = SAVE_FB;
        end else if (step_r == STEP_N1) begin
          cmd.save = SAVE_N1;
        end else begin
          cmd.save = SAVE_N2;
        end
        step_nxt  = step_r + 4'd1;
        state_nxt = S_MAC_HI;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[src/osfpi_datapath.sv]
// ----------------------------------------------------------------------------
// osfpi_datapath
// shared 32x32 multiplier, saturating accumulator, controller state and gains
// ----------------------------------------------------------------------------
`default_nettype none

module osfpi_datapath #(
  parameter int SUM_BITS = 40
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire osfpi_pkg::dp_cmd_t                     cmd,
  input  wire logic [osfpi_pkg::MV_W-1:0]             in_setpoint,
  input  wire logic [osfpi_pkg::MV_W-1:0]             in_feedback,
  input  wire logic                                   cfg_we,
  input  wire logic [osfpi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [osfpi_pkg::GAIN_W-1:0]           cfg_data,
  output logic [osfpi_pkg::DUTY_BITS-1:0]             out_duty,
  output logic [osfpi_pkg::VOLT_W-1:0]                out_drive,
  output logic signed [osfpi_pkg::ERR_W-1:0]          out_error
);
  import osfpi_pkg::*;

  localparam int SPQ_W = 64 - SP_RECIP_SH;
  localparam int VQ_W  = 64 - V_RECIP_SH;
  localparam int V_W   = 19;
  localparam int Z_W   = 14;

  // gains
  logic signed [GAIN_W-1:0] k1_r, k2_r, ki_r, l1_r, l2_r, b1_r, b2_r;
  // loop state
  logic signed [GAIN_W-1:0]   e1_r, e2_r;
  logic        [VOLT_W-1:0]   u_r;
  logic signed [SUM_BITS-1:0] sum_r, sum_nxt;
  // per-item working registers
  logic        [MV_W-1:0]     sp_mv_r, fb_mv_r;
  logic        [VOLT_W-1:0]   sp_r;
  logic        [V_W-1:0]      v_r;
  logic signed [OPA_W-1:0]    diff_r;
  logic signed [ERR_W-1:0]    err_r;
  logic signed [GAIN_W-1:0]   n1_r, n2_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic        [63:0]         prod_r, hi_r;
  logic        [DUTY_BITS-1:0] duty_out_r;
  logic        [VOLT_W-1:0]   drive_out_r;
  logic signed [ERR_W-1:0]    err_out_r;

  logic signed [OPA_W-1:0]  op_a;
  logic signed [63:0]       op_b;
  logic        [31:0]       ua, mul_a, mul_b;
  logic        [63:0]       ub, mag_raw, mag;
  logic                     neg;
  logic signed [ACC_W-1:0]  q_val, base, acc_sum, acc_nxt;
  logic        [31:0]       sp_x, v_x, sp_rem, v_rem;
  logic        [SPQ_W-1:0]  sp_qe, sp_q;
  logic        [VQ_W-1:0]   v_qe, v_q;
  logic        [VOLT_W-1:0] clamp_volt;
  logic signed [GAIN_W-1:0] clamp_est;
  logic signed [SUM_BITS:0] sum_wide;
  logic        [31:0]       duty_y;
  logic        [Z_W-1:0]    duty_z;
  logic        [31:0]       duty_p;

  // operand selection
  always_comb begin
    case (cmd.mac.a_sel)
      A_C3:    op_a = OPA_W'(C3_Q);
      A_ACC:   op_a = acc_r[OPA_W-1:0];
      A_L1:    op_a = OPA_W'(l1_r);
      A_B1:    op_a = OPA_W'(b1_r);
      A_A21:   op_a = OPA_W'(A21_Q);
      A_A22:   op_a = OPA_W'(A22_Q);
      A_B2:    op_a = OPA_W'(b2_r);
      A_L2:    op_a = OPA_W'(l2_r);
      A_NKI:   op_a = -OPA_W'(ki_r);
      A_K1:    op_a = OPA_W'(k1_r);
      A_K2:    op_a = OPA_W'(k2_r);
      default: op_a = '0;
    endcase
    case (cmd.mac.b_sel)
      B_V:     op_b = $signed(64'(v_r));
      B_DIFF:  op_b = 64'(diff_r);
      B_E1:    op_b = 64'(e1_r);
      B_E2:    op_b = 64'(e2_r);
      B_U:     op_b = $signed(64'(u_r));
      B_SUM:   op_b = 64'(sum_r);
      default: op_b = '0;
    endcase
    case (cmd.mac.base_sel)
      BASE_ACC:  base = acc_r;
      BASE_ZERO: base = '0;
      BASE_E2:   base = ACC_W'(e2_r);
      BASE_NC2:  base = -ACC_W'(C2_Q);
      BASE_C1:   base = ACC_W'(C1_Q);
      BASE_NC0:  base = -ACC_W'(C0_Q);
      default:   base = '0;
    endcase
  end

  assign ua  = op_a[OPA_W-1] ? 32'(-op_a) : 32'(op_a);
  assign ub  = op_b[63] ? 64'(-op_b) : 64'(op_b);
  assign neg = op_a[OPA_W-1] ^ op_b[63] ^ cmd.mac.neg;

  // millivolt scaling operands
  assign sp_x = (32'(sp_mv_r) * 32'd12) << FRAC_BITS;
  assign v_x  = 32'(fb_mv_r) << FRAC_BITS;

  always_comb begin
    case (cmd.mul_sel)
      MUL_SP: begin
        mul_a = sp_x;
        mul_b = 32'(SP_RECIP);
      end
      MUL_V: begin
        mul_a = v_x;
        mul_b = 32'(V_RECIP);
      end
      MUL_HI: begin
        mul_a = ua;
        mul_b = ub[63:32];
      end
      MUL_LO: begin
        mul_a = ua;
        mul_b = ub[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // reciprocal estimate is at most one low, one correction step
  always_comb begin
    sp_qe  = prod_r[63:SP_RECIP_SH];
    sp_rem = sp_x - 32'(sp_qe) * 32'(SP_DIV);
    sp_q   = (sp_rem >= 32'(SP_DIV)) ? sp_qe + 1'b1 : sp_qe;
    v_qe   = prod_r[63:V_RECIP_SH];
    v_rem  = v_x - 32'(v_qe) * 32'(V_DIV);
    v_q    = (v_rem >= 32'(V_DIV)) ? v_qe + 1'b1 : v_qe;
  end

  // q-format product from the two partial products, then saturating add
  always_comb begin
    mag_raw = (hi_r << (32 - FRAC_BITS)) + (prod_r >> FRAC_BITS);
    if (hi_r >= HI_LIMIT) begin
      mag = BIG_MAG;
    end else if (mag_raw > BIG_MAG) begin
      mag = BIG_MAG;
    end else begin
      mag = mag_raw;
    end
    q_val   = neg ? -$signed(mag) : $signed(mag);
    acc_sum = base + q_val;
    if (acc_sum > BIG_LIMIT) begin
      acc_nxt = BIG_LIMIT;
    end else if (acc_sum < -BIG_LIMIT) begin
      acc_nxt = -BIG_LIMIT;
    end else begin
      acc_nxt = acc_sum;
    end
  end

  // accumulator clamps
  always_comb begin
    if (acc_r < 0) begin
      clamp_volt = '0;
    end else if (acc_r > $signed(64'(VOLT_MAX))) begin
      clamp_volt = VOLT_MAX;
    end else begin
      clamp_volt = acc_r[VOLT_W-1:0];
    end
    if (acc_r > ACC_W'(32'sh7fffffff)) begin
      clamp_est = 32'sh7fffffff;
    end else if (acc_r < -ACC_W'(33'sh080000000)) begin
      clamp_est = 32'sh80000000;
    end else begin
      clamp_est = acc_r[GAIN_W-1:0];
    end
  end

  // error sum saturates at its width
  always_comb begin
    sum_wide = {sum_r[SUM_BITS-1], sum_r} + (SUM_BITS+1)'(err_r);
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      sum_nxt = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                   : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      sum_nxt = sum_wide[SUM_BITS-1:0];
    end
  end

  // duty = drive * (2^n - 1) / (3 * 2^(frac+2))
  always_comb begin
    duty_y = (32'(u_r) << DUTY_BITS) - 32'(u_r);
    duty_z = Z_W'(duty_y >> (FRAC_BITS + 2));
    duty_p = (32'(duty_z) * 32'(DIV3_MUL)) >> DIV3_SH;
  end

  // gains and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r  <= K1_RESET;
      k2_r  <= K2_RESET;
      ki_r  <= KI_RESET;
      l1_r  <= L1_RESET;
      l2_r  <= L2_RESET;
      b1_r  <= B1_RESET;
      b2_r  <= B2_RESET;
      e1_r  <= '0;
      e2_r  <= '0;
      u_r   <= '0;
      sum_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_K1:  k1_r <= cfg_data;
          CFG_K2:  k2_r <= cfg_data;
          CFG_KI:  ki_r <= cfg_data;
          CFG_L1:  l1_r <= cfg_data;
          CFG_L2:  l2_r <= cfg_data;
          CFG_B1:  b1_r <= cfg_data;
          CFG_B2:  b2_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        e1_r  <= n1_r;
        e2_r  <= n2_r;
        u_r   <= clamp_volt;
        sum_r <= sum_nxt;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.capture) begin
      sp_mv_r <= in_setpoint;
      fb_mv_r <= in_feedback;
    end
    if (cmd.sp_fix) begin
      sp_r <= (32'(sp_q) > 32'(VOLT_MAX)) ? VOLT_MAX : VOLT_W'(sp_q);
    end
    if (cmd.v_fix) begin
      v_r <= V_W'(v_q);
    end
    if (cmd.mul_sel == MUL_SP) begin
      acc_r <= ACC_W'(C3_Q);
    end else if (cmd.acc_load) begin
      acc_r <= acc_nxt;
    end
    if (cmd.hi_load) begin
      hi_r <= prod_r;
    end
    case (cmd.save)
      SAVE_FB: begin
        diff_r <= $signed(OPA_W'(clamp_volt)) - OPA_W'(e1_r);
        err_r  <= $signed(ERR_W'(sp_r)) - $signed(ERR_W'(clamp_volt));
      end
      SAVE_N1: n1_r <= clamp_est;
      SAVE_N2: n2_r <= clamp_est;
      default: ;
    endcase
    if (cmd.out_load) begin
      duty_out_r  <= DUTY_BITS'(duty_p);
      drive_out_r <= u_r;
      err_out_r   <= err_r;
    end
  end

  assign out_duty  = duty_out_r;
  assign out_drive = drive_out_r;
  assign out_error = err_out_r;

endmodule

`default_nettype wire

[src/observer_state_feedback_pi_control_core.sv]
// ----------------------------------------------------------------------------
// observer_state_feedback_pi_control_core
// observer based state feedback voltage controller with integral action
// ----------------------------------------------------------------------------
// One transfer on in_ch is one sample period. The block works on one sample at
// a time: in_ch.ready is high only while the sequencer is idle. A sample goes
// through millivolt scaling, 12 multiply-accumulate steps (high and low partial
// product, then accumulate) on the single shared 32x32 multiplier, save steps,
// commit and output load into the output register. The result register parts
// the two sides, so the next sample is taken while a result still waits on
// out_ch; a new result waits in the sequencer only if the previous one is still
// untaken. Gains are to be written by the user on the cfg port between samples
// and take effect at the next sample; the block itself does not enforce it.
`default_nettype none

module observer_state_feedback_pi_control_core #(
  parameter int SUM_BITS = 40
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  osfpi_in_if.sink                                in_ch,
  osfpi_out_if.source                             out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [osfpi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [osfpi_pkg::GAIN_W-1:0]       cfg_data
);
  import osfpi_pkg::*;

  // command bundle from sequencer to datapath
  dp_cmd_t cmd;
  logic    in_ready;
  logic    out_valid;

  // sequencer: scaling, mac steps, commit, output handshake
  osfpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // datapath: gains, observer and integrator state, shared multiplier
  osfpi_datapath #(
    .SUM_BITS (SUM_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_setpoint (in_ch.setpoint_millivolts),
    .in_feedback (in_ch.feedback_millivolts),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_duty    (out_ch.pwm_duty),
    .out_drive   (out_ch.drive_volts),
    .out_error   (out_ch.error_volts)
  );

  // handshake outputs
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

[src/osfpi_checker.sv]
// ----------------------------------------------------------------------------
// osfpi_checker
// port level checks on the result channel of the controller
// ----------------------------------------------------------------------------
`default_nettype none

`include "observer_state_feedback_pi_control_core_defines.svh"

module osfpi_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic        [11:0] pwm_duty,
  input wire logic        [19:0] drive_volts,
  input wire logic signed [20:0] error_volts
);

  // a stalled result stays offered
  `OSFPI_ASSERT(a_valid_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // a stalled result keeps its payload
  `OSFPI_ASSERT(a_payload_hold, out_valid && !out_ready |=> $stable(pwm_duty) && $stable(drive_volts) && $stable(error_volts), "stalled result changed")

  // drive is clamped to twelve volts
  `OSFPI_ASSERT(a_drive_range, out_valid |-> drive_volts <= 20'd786432, "drive above 12 V")

  // zero drive maps to zero duty
  `OSFPI_ASSERT(a_zero_duty, out_valid && drive_volts == 20'd0 |-> pwm_duty == 12'd0, "duty without drive")

  // reset empties the result register
  `OSFPI_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind observer_state_feedback_pi_control_core osfpi_checker u_osfpi_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pwm_duty    (out_ch.pwm_duty),
  .drive_volts (out_ch.drive_volts),
  .error_volts (out_ch.error_volts)
);

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the observer state feedback controller: drives
// millivolt samples, rewrites the gains between phases and checks every
// result against a cycle-free fixed-point predictor
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import osfpi_pkg::*;

  // ------------------------------------------------------------------------
  // constants of the predictor (Q16.16)
  // ------------------------------------------------------------------------
  localparam longint Q1        = 64'sd65536;
  localparam longint VOLT_TOP  = 12 * Q1;
  localparam longint SAT_LIM   = 64'sd1 << 61;
  localparam longint POLY_C3   = (64'sd1506 * Q1 + 5000) / 10000;
  localparam longint POLY_C2   = (64'sd487 * Q1 + 500) / 1000;
  localparam longint POLY_C1   = (64'sd40233 * Q1 + 5000) / 10000;
  localparam longint POLY_C0   = (64'sd358 * Q1 + 5000) / 10000;
  localparam longint PLANT_A21 = -((64'sd846 * Q1 + 500) / 1000);
  localparam longint PLANT_A22 = (64'sd1844 * Q1 + 500) / 1000;
  localparam int     SUM_W     = 40;
  localparam longint SUM_TOP   = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam longint SUM_BOT   = -SUM_TOP - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;  // no register here
  localparam int     MV_SPAN   = 3300;
  localparam int     IDLE_PCT  = 23;
  localparam int     HOLD_LEN  = 400;
  localparam int     STALL_LIMIT = 3000;
  localparam int     DRAIN_CYCLES = 60;

  typedef struct {
    logic [11:0] duty;
    logic [19:0] drive;
    logic [20:0] err;
  } ctrl_result_t;

  // ------------------------------------------------------------------------
  // clock, reset, channels
  // ------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data = '0;

  always #2 clk = ~clk;

  osfpi_in_if  in_ch();
  osfpi_out_if out_ch();

  observer_state_feedback_pi_control_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ------------------------------------------------------------------------
  // predictor state: gains mirror the register file, the rest mirrors the
  // controller's own memory
  // ------------------------------------------------------------------------
  longint gain_k1 = K1_RESET, gain_k2 = K2_RESET, gain_ki = KI_RESET;
  longint gain_l1 = L1_RESET, gain_l2 = L2_RESET;
  longint gain_b1 = B1_RESET, gain_b2 = B2_RESET;
  longint est_one = 0, est_two = 0, last_drive = 0, err_total = 0;

  ctrl_result_t pending_results[$];
  int  fail_count = 0;
  bit  idle_on = 1'b0;
  bit  hold_pending = 1'b0;
  bit  hold_taken = 1'b0;
  int  hold_left = 0;
  int  stall_cycles = 0;

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint sat_add(longint a, longint b);
    return clip(a + b, -SAT_LIM, SAT_LIM);
  endfunction

  // q multiply: magnitude product split in two 32-bit halves of b, truncated
  function automatic longint q_mul(longint a, longint b);
    bit [63:0] ua, ub, hi, lo, mag;
    bit neg;
    ua  = a < 0 ? 64'(-a) : 64'(a);
    ub  = b < 0 ? 64'(-b) : 64'(b);
    neg = (a < 0) != (b < 0);
    hi  = ua * (ub >> 32);
    lo  = ua * (ub & 64'hFFFF_FFFF);
    if (hi >= (64'd1 << (29 + 16))) begin
      mag = 64'(SAT_LIM);
    end else begin
      mag = (hi << 16) + (lo >> 16);
      if (mag > 64'(SAT_LIM)) mag = 64'(SAT_LIM);
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // one sample period of the controller
  function automatic ctrl_result_t control_step(logic [11:0] sp_mv, logic [11:0] fb_mv);
    longint sp, v, fb, err, e1, e2, u, n1, n2, drive, diff;
    ctrl_result_t r;
    sp = clip((longint'(sp_mv) * 12 * Q1) / MV_SPAN, 0, VOLT_TOP);
    v  = (longint'(fb_mv) * Q1) / 1000;
    fb = sat_add(q_mul(POLY_C3, v), -POLY_C2);
    fb = sat_add(q_mul(fb, v), POLY_C1);
    fb = sat_add(q_mul(fb, v), -POLY_C0);
    fb = clip(fb, 0, VOLT_TOP);
    err  = sp - fb;
    e1   = est_one;
    e2   = est_two;
    u    = last_drive;
    diff = fb - e1;
    n1 = sat_add(sat_add(q_mul(gain_l1, diff), e2), q_mul(gain_b1, u));
    n2 = sat_add(q_mul(PLANT_A21, e1), q_mul(PLANT_A22, e2));
    n2 = sat_add(n2, q_mul(gain_b2, u));
    n2 = sat_add(n2, q_mul(gain_l2, diff));
    drive = q_mul(-gain_ki, err_total);
    drive = sat_add(drive, -q_mul(gain_k1, e1));
    drive = sat_add(drive, -q_mul(gain_k2, e2));
    drive = clip(drive, 0, VOLT_TOP);
    est_one    = clip(n1, -64'sd2147483648, 64'sd2147483647);
    est_two    = clip(n2, -64'sd2147483648, 64'sd2147483647);
    last_drive = drive;
    if (err > 0 && err_total > SUM_TOP - err) err_total = SUM_TOP;
    else if (err < 0 && err_total < SUM_BOT - err) err_total = SUM_BOT;
    else err_total = err_total + err;
    r.duty  = 12'((drive * 4095) / VOLT_TOP);
    r.drive = 20'(drive);
    r.err   = 21'(err);
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // input side: one transfer per call, valid dropped right after it
  // ------------------------------------------------------------------------
  task automatic send_sample(logic [11:0] sp_mv, logic [11:0] fb_mv);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(40, 1);
    repeat (gap) @(posedge clk);
    in_ch.valid               <= 1'b1;
    in_ch.setpoint_millivolts <= sp_mv;
    in_ch.feedback_millivolts <= fb_mv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // transfer at this edge
    pending_results.push_back(control_step(sp_mv, fb_mv));
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // gain write, only once the controller has nothing in flight
  task automatic write_gain(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    longint sv;
    sv = longint'(signed'(val));
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_K1: gain_k1 = sv;
      CFG_K2: gain_k2 = sv;
      CFG_KI: gain_ki = sv;
      CFG_L1: gain_l1 = sv;
      CFG_L2: gain_l2 = sv;
      CFG_B1: gain_b1 = sv;
      CFG_B2: gain_b2 = sv;
      default: ;  // unknown index is ignored by the block as well
    endcase
  endtask

  task automatic write_all_gains(logic [31:0] k1, logic [31:0] k2, logic [31:0] ki,
                                 logic [31:0] l1, logic [31:0] l2, logic [31:0] b1,
                                 logic [31:0] b2);
    write_gain(CFG_K1, k1);
    write_gain(CFG_K2, k2);
    write_gain(CFG_KI, ki);
    write_gain(CFG_L1, l1);
    write_gain(CFG_L2, l2);
    write_gain(CFG_B1, b1);
    write_gain(CFG_B2, b2);
  endtask

  task automatic write_reset_gains();
    write_all_gains(K1_RESET, K2_RESET, KI_RESET, L1_RESET, L2_RESET, B1_RESET, B2_RESET);
  endtask

  // mostly in-range readings, sometimes the whole 12-bit field
  function automatic logic [11:0] pick_mv();
    return ($urandom_range(99) < 15) ? 12'($urandom_range(4095))
                                     : 12'($urandom_range(MV_SPAN));
  endfunction

  // ------------------------------------------------------------------------
  // result side: ready with random stalls plus one long hold-off
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_pending && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end
  end

  // result checker: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    ctrl_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no prediction pending");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.pwm_duty !== exp_r.duty) begin
          $error("pwm_duty expected %0d actual %0d", exp_r.duty, out_ch.pwm_duty);
          fail_count++;
        end
        if (out_ch.drive_volts !== exp_r.drive) begin
          $error("drive_volts expected %0d actual %0d", exp_r.drive, out_ch.drive_volts);
          fail_count++;
        end
        if (out_ch.error_volts !== exp_r.err) begin
          $error("error_volts expected %0d actual %0d",
                 $signed(exp_r.err), out_ch.error_volts);
          fail_count++;
        end
      end
    end
  end

  // watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // corners of both readings with the reset gains: zero, full span,
  // above span (setpoint saturates, feedback clamps), single bits
  task automatic test_reading_corners();
    send_sample(12'd0, 12'd0);
    send_sample(12'd3300, 12'd3300);
    send_sample(12'd4095, 12'd4095);
    send_sample(12'd4095, 12'd0);
    send_sample(12'd0, 12'd4095);
    send_sample(12'd3300, 12'd0);
    send_sample(12'd0, 12'd3300);
    send_sample(12'hAAA, 12'h555);
    send_sample(12'h555, 12'hAAA);
    send_sample(12'd1, 12'd1);
    send_sample(12'd2000, 12'd10);   // feedback low: polynomial result small but positive
    send_sample(12'd2500, 12'd1200);
    send_sample(12'd1650, 12'd1650);
    send_sample(12'd3301, 12'd3299);
  endtask

  // register file: each register written, extremes, unknown index ignored
  task automatic test_gain_extremes();
    write_all_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(12'd3300, 12'd0);
    send_sample(12'd0, 12'd3300);
    send_sample(12'd4095, 12'd100);
    write_all_gains(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_sample(12'd3300, 12'd3300);
    send_sample(12'd100, 12'd4095);
    send_sample(12'd2000, 12'd500);
    write_all_gains('0, '0, '0, '0, '0, '0, '0);
    send_sample(12'd1000, 12'd2000);
    write_gain(CFG_UNUSED, 32'h1234_5678);
    send_sample(12'd3000, 12'd400);
    write_reset_gains();
    send_sample(12'd2200, 12'd1100);
  endtask

  // bulk random traffic over several gain settings, idling on and off
  task automatic test_random_traffic();
    for (int phase = 0; phase < 11; phase++) begin
      idle_on = (phase != 3);  // one long stretch without idling
      case (phase % 4)
        0: write_reset_gains();
        1: write_gain(CFG_KI, 32'($urandom_range(400000)) * -1);
        2: write_all_gains($urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom);
        default: begin
          write_gain(CFG_L1, 32'($urandom_range(200000)));
          write_gain(CFG_B2, 32'($urandom_range(20000)));
        end
      endcase
      for (int n = 0; n < 100; n++) send_sample(pick_mv(), pick_mv());
    end
    idle_on = 1'b1;
  endtask

  // receiver holds off while samples keep coming: the block fills and
  // stalls its input, then drains
  task automatic test_result_backpressure();
    write_reset_gains();
    hold_pending = 1'b1;
    for (int n = 0; n < 20; n++) send_sample(pick_mv(), pick_mv());
  endtask

  initial begin
    in_ch.valid               = 1'b0;
    in_ch.setpoint_millivolts = '0;
    in_ch.feedback_millivolts = '0;
    out_ch.ready              = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reading_corners();
    test_gain_extremes();
    idle_on = 1'b1;
    test_result_backpressure();
    test_random_traffic();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+src
src/osfpi_pkg.sv
src/osfpi_in_if.sv
src/osfpi_out_if.sv
src/osfpi_ctrl.sv
src/osfpi_datapath.sv
src/observer_state_feedback_pi_control_core.sv
src/osfpi_checker.sv
dv/testbench.sv
